// ===== rtl/core/sbt_pkg.sv =====
// Shared types and constants for the script byte tokenizer.
`timescale 1ns / 1ps
package sbt_pkg;

  // Field widths of the record format.
  localparam int unsigned OffsetBits      = 24;
  localparam int unsigned LineBits        = 20;
  localparam int unsigned IndentCountBits = 16;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]                 record_kind;
    logic [OffsetBits-1:0]      start_offset;
    logic [OffsetBits-1:0]      end_offset;
    logic [LineBits-1:0]        line_number;
    logic [IndentCountBits-1:0] indent_depth;
    logic [2:0]                 error_code;
    logic                       last_of_run;
  } out_item_t;

  localparam int unsigned MaxRec = 4;

  typedef enum logic [7:0] {
    M_INDENT   = 8'b0000_0001,
    M_IDLE     = 8'b0000_0010,
    M_NAME     = 8'b0000_0100,
    M_NUMBER   = 8'b0000_1000,
    M_DOTSTART = 8'b0001_0000,
    M_STRING   = 8'b0010_0000,
    M_OPER     = 8'b0100_0000,
    M_COMMENT  = 8'b1000_0000
  } mode_e;

  localparam logic [4:0] K_NAME   = 5'd0;
  localparam logic [4:0] K_INT    = 5'd1;
  localparam logic [4:0] K_FLOAT  = 5'd2;
  localparam logic [4:0] K_STRING = 5'd3;
  localparam logic [4:0] K_COMMA  = 5'd4;
  localparam logic [4:0] K_COLON  = 5'd5;
  localparam logic [4:0] K_LPAREN = 5'd6;
  localparam logic [4:0] K_RPAREN = 5'd7;
  localparam logic [4:0] K_OPBASE = 5'd8;
  localparam logic [4:0] K_LINE   = 5'd20;
  localparam logic [4:0] K_ERROR  = 5'd21;
  localparam logic [4:0] K_DONE   = 5'd22;

  localparam logic [2:0] E_NONE   = 3'd0;
  localparam logic [2:0] E_DOT    = 3'd1;
  localparam logic [2:0] E_STRING = 3'd2;
  localparam logic [2:0] E_CHAR   = 3'd3;
  localparam logic [2:0] E_INDENT = 3'd4;
  localparam logic [2:0] E_MIXED  = 3'd5;

  // Pending operator codes; record kind is K_OPBASE + 2*code (+1 with '=').
  localparam logic [2:0] OP_EQ    = 3'd0;
  localparam logic [2:0] OP_BANG  = 3'd1;
  localparam logic [2:0] OP_STAR  = 3'd2;
  localparam logic [2:0] OP_SLASH = 3'd3;
  localparam logic [2:0] OP_PLUS  = 3'd4;
  localparam logic [2:0] OP_MINUS = 3'd5;

  // One classified byte's worth of records, handed from front to back.
  typedef struct packed {
    logic [2:0]                  count;
    out_item_t [MaxRec-1:0]      rec;
  } burst_t;

  // Byte class for the scanner.
  typedef struct packed {
    logic alpha;
    logic digit;
    logic blank;   // space, tab, CR
    logic op;
    logic punct;
  } cls_t;

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    c.alpha = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
    c.digit = b >= 8'h30 && b <= 8'h39;
    c.blank = b == 8'h20 || b == 8'h09 || b == 8'h0d;
    c.op    = b == 8'h3d || b == 8'h21 || b == 8'h2a || b == 8'h2f || b == 8'h2b
              || b == 8'h2d;
    c.punct = b == 8'h2c || b == 8'h3a || b == 8'h28 || b == 8'h29;
    return c;
  endfunction

  function automatic logic [2:0] op_code(input logic [7:0] b);
    logic [2:0] r;
    unique case (b)
      8'h3d:   r = OP_EQ;
      8'h21:   r = OP_BANG;
      8'h2a:   r = OP_STAR;
      8'h2f:   r = OP_SLASH;
      8'h2b:   r = OP_PLUS;
      default: r = OP_MINUS;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] b);
    logic [4:0] r;
    unique case (b)
      8'h2c:   r = K_COMMA;
      8'h3a:   r = K_COLON;
      8'h28:   r = K_LPAREN;
      default: r = K_RPAREN;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/script_byte_tokenizer.sv =====
// Top level of the script byte tokenizer.
`timescale 1ns / 1ps
// Streaming tokenizer: one text byte per beat in, token, line-end, error and done
// records out through a queue. The front end scans one byte a cycle and produces
// up to four records for it; these land in an eight-entry record queue that the
// consumer drains one beat a cycle. A byte is taken every cycle as long as the
// queue has room for a worst-case burst of four records; sustained rate falls
// below one byte a cycle only when the consumer pops slower than records arrive.
// Records for a byte are written into the queue when it is taken, behind any
// records still queued. After an error the block is silent until the final byte,
// which always yields a done record and rearms the scanner for the next text.
// Offset, line and indent widths are fixed in the package.
module script_byte_tokenizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  sbt_pkg::in_item_t   in_item_i,
  output logic                empty,
  input  logic                pop,
  output sbt_pkg::out_item_t  out_item_o
);

  sbt_pkg::burst_t burst;
  logic            room;

  sbt_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(push && room),
    .item_i (in_item_i),
    .burst_o(burst)
  );

  sbt_back #(
    .DEPTH_LOG2(3)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .burst_i(burst),
    .room_o (room),
    .empty_o(empty),
    .pop_i  (pop),
    .rec_o  (out_item_o)
  );

  assign full = !room;

endmodule

// ===== rtl/core/sbt_front.sv =====
// Front end: scanner state machine, one byte a cycle while valid_i is high, builds up to four records.
`timescale 1ns / 1ps
module sbt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  sbt_pkg::in_item_t   item_i,
  output sbt_pkg::burst_t     burst_o
);

  localparam int unsigned OFFSET_BITS       = sbt_pkg::OffsetBits;
  localparam int unsigned LINE_BITS         = sbt_pkg::LineBits;
  localparam int unsigned INDENT_COUNT_BITS = sbt_pkg::IndentCountBits;

  localparam logic [OFFSET_BITS-1:0]       OffMax = '1;
  localparam logic [LINE_BITS-1:0]         LineMax = '1;
  localparam logic [INDENT_COUNT_BITS-1:0] IndMax = '1;

  sbt_pkg::mode_e                mode_q, mode_d;
  logic [OFFSET_BITS-1:0]        pos_q, pos_d, tstart_q, tstart_d;
  logic [LINE_BITS-1:0]          line_q, line_d;
  logic [INDENT_COUNT_BITS-1:0]  isp_q, isp_d, itab_q, itab_d;
  logic                          has_tok_q, has_tok_d, sp_seen_q, sp_seen_d;
  logic                          tab_seen_q, tab_seen_d, dot_q, dot_d;
  logic [2:0]                    pop_q, pop_d;
  logic                          halt_q, halt_d;

  logic [7:0]             b;
  logic                   fin;
  sbt_pkg::cls_t          c;
  logic [OFFSET_BITS-1:0] nxt;
  logic [INDENT_COUNT_BITS:0] lvl_sum;
  logic [15:0]            lvl;

  sbt_pkg::burst_t bu;

  // builds one record stamped with the line number passed in; the caller appends it
  function automatic sbt_pkg::out_item_t mk(input logic [4:0] k,
                                            input logic [OFFSET_BITS-1:0] s,
                                            input logic [OFFSET_BITS-1:0] e,
                                            input logic [LINE_BITS-1:0] ln,
                                            input logic [15:0] ind,
                                            input logic [2:0] err);
    sbt_pkg::out_item_t r;
    r.record_kind  = k;
    r.start_offset = 24'(s);
    r.end_offset   = 24'(e);
    r.line_number  = 20'(ln);
    r.indent_depth = ind;
    r.error_code   = err;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic go_idle;
    logic do_end;
    logic [OFFSET_BITS-1:0] end_at;
    logic [OFFSET_BITS-1:0] endp;
    logic sps, tbs;
    b   = item_i.text_byte;
    fin = item_i.final_byte;
    c   = sbt_pkg::classify(b);
    nxt = (pos_q == OffMax) ? OffMax : pos_q + 1'b1;
    endp = nxt;
    mode_d = mode_q; pos_d = pos_q; tstart_d = tstart_q; line_d = line_q;
    isp_d = isp_q; itab_d = itab_q; has_tok_d = has_tok_q; sp_seen_d = sp_seen_q;
    tab_seen_d = tab_seen_q; dot_d = dot_q; pop_d = pop_q; halt_d = halt_q;
    bu = '0;
    go_idle = 1'b0;
    do_end = 1'b0;
    end_at = pos_q;
    lvl_sum = '0;
    lvl = '0;
    sps = 1'b0; tbs = 1'b0;

    // per-byte scan
    if (!halt_q) begin
      unique case (mode_q)
        sbt_pkg::M_INDENT: begin
          if (b == 8'h20) isp_d = (isp_q == IndMax) ? IndMax : isp_q + 1'b1;
          else if (b == 8'h09) itab_d = (itab_q == IndMax) ? IndMax : itab_q + 1'b1;
          else go_idle = 1'b1;
        end
        sbt_pkg::M_IDLE: go_idle = 1'b1;
        sbt_pkg::M_NAME: begin
          if (!(c.alpha || c.digit)) begin
            bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_NAME, tstart_q, pos_q, line_d, '0,
                                       sbt_pkg::E_NONE);
            bu.count = bu.count + 1'b1; has_tok_d = 1'b1; go_idle = 1'b1;
          end
        end
        sbt_pkg::M_DOTSTART: begin
          if (c.digit) begin
            mode_d = sbt_pkg::M_NUMBER; dot_d = 1'b1;
          end else begin
            bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_ERROR, tstart_q, pos_q, line_d, '0,
                                       sbt_pkg::E_DOT);
            bu.count = bu.count + 1'b1; halt_d = 1'b1;
          end
        end
        sbt_pkg::M_NUMBER: begin
          if (c.digit) begin
          end else if (b == 8'h2e && !dot_q) begin
            dot_d = 1'b1;
          end else begin
            bu.rec[bu.count[1:0]] = mk(dot_q ? sbt_pkg::K_FLOAT : sbt_pkg::K_INT,
                                       tstart_q, pos_q, line_d, '0, sbt_pkg::E_NONE);
            bu.count = bu.count + 1'b1; has_tok_d = 1'b1; go_idle = 1'b1;
          end
        end
        sbt_pkg::M_STRING: begin
          if (b == 8'h22) begin
            bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_STRING, tstart_q, nxt, line_d, '0,
                                       sbt_pkg::E_NONE);
            bu.count = bu.count + 1'b1; has_tok_d = 1'b1; mode_d = sbt_pkg::M_IDLE;
          end else if (b == 8'h0a) begin
            bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_ERROR, tstart_q, pos_q, line_d, '0,
                                       sbt_pkg::E_STRING);
            bu.count = bu.count + 1'b1; halt_d = 1'b1;
          end
        end
        sbt_pkg::M_OPER: begin
          if (b == 8'h3d) begin
            bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_OPBASE + {1'b0, pop_q, 1'b1},
                                       tstart_q, nxt, line_d, '0, sbt_pkg::E_NONE);
            bu.count = bu.count + 1'b1; has_tok_d = 1'b1; mode_d = sbt_pkg::M_IDLE;
          end else begin
            bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_OPBASE + {1'b0, pop_q, 1'b0},
                                       tstart_q, pos_q, line_d, '0, sbt_pkg::E_NONE);
            bu.count = bu.count + 1'b1; has_tok_d = 1'b1; go_idle = 1'b1;
          end
        end
        sbt_pkg::M_COMMENT: if (b == 8'h0a) go_idle = 1'b1;
        default: go_idle = 1'b1;
      endcase

      if (go_idle) begin
        mode_d = sbt_pkg::M_IDLE;
        if (b == 8'h0a) begin
          do_end = 1'b1; end_at = pos_q;
        end else if (c.blank) begin
        end else begin
          tstart_d = pos_q;
          if (c.alpha) mode_d = sbt_pkg::M_NAME;
          else if (c.digit) begin
            mode_d = sbt_pkg::M_NUMBER; dot_d = 1'b0;
          end else if (b == 8'h2e) mode_d = sbt_pkg::M_DOTSTART;
          else if (b == 8'h22) mode_d = sbt_pkg::M_STRING;
          else if (c.punct) begin
            bu.rec[bu.count[1:0]] = mk(sbt_pkg::punct_kind(b), pos_q, nxt, line_d, '0,
                                       sbt_pkg::E_NONE);
            bu.count = bu.count + 1'b1; has_tok_d = 1'b1;
          end else if (c.op) begin
            pop_d = sbt_pkg::op_code(b); mode_d = sbt_pkg::M_OPER;
          end else if (b == 8'h23) mode_d = sbt_pkg::M_COMMENT;
          else begin
            bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_ERROR, pos_q, nxt, line_d, '0,
                                       sbt_pkg::E_CHAR);
            bu.count = bu.count + 1'b1; halt_d = 1'b1;
          end
        end
      end
    end

    // end-of-text flush, run on the updated state
    if (fin && !halt_d && !do_end) begin
      do_end = 1'b1; end_at = endp;
      unique case (mode_d)
        sbt_pkg::M_NAME: begin
          bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_NAME, tstart_d, endp, line_d, '0,
                                     sbt_pkg::E_NONE);
          bu.count = bu.count + 1'b1; has_tok_d = 1'b1;
        end
        sbt_pkg::M_NUMBER: begin
          bu.rec[bu.count[1:0]] = mk(dot_d ? sbt_pkg::K_FLOAT : sbt_pkg::K_INT,
                                     tstart_d, endp, line_d, '0, sbt_pkg::E_NONE);
          bu.count = bu.count + 1'b1; has_tok_d = 1'b1;
        end
        sbt_pkg::M_DOTSTART: begin
          bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_ERROR, tstart_d, endp, line_d, '0,
                                     sbt_pkg::E_DOT);
          bu.count = bu.count + 1'b1; halt_d = 1'b1; do_end = 1'b0;
        end
        sbt_pkg::M_STRING: begin
          bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_ERROR, tstart_d, endp, line_d, '0,
                                     sbt_pkg::E_STRING);
          bu.count = bu.count + 1'b1; halt_d = 1'b1; do_end = 1'b0;
        end
        sbt_pkg::M_OPER: begin
          bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_OPBASE + {1'b0, pop_d, 1'b0},
                                     tstart_d, endp, line_d, '0, sbt_pkg::E_NONE);
          bu.count = bu.count + 1'b1; has_tok_d = 1'b1;
        end
        default: ;
      endcase
    end

    // a newline in the scan and the flush cannot both end a line: newline leaves
    // the scanner in line-start mode, whose flush is only the line end below
    if (do_end) begin
      if (has_tok_d) begin
        if (isp_d[1:0] != 2'b00) begin
          bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_ERROR, end_at, end_at, line_d, '0,
                                     sbt_pkg::E_INDENT);
          bu.count = bu.count + 1'b1; halt_d = 1'b1;
        end else begin
          sps = sp_seen_d | (isp_d != '0);
          tbs = tab_seen_d | (itab_d != '0);
          sp_seen_d = sps; tab_seen_d = tbs;
          if (sps && tbs) begin
            bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_ERROR, end_at, end_at, line_d, '0,
                                       sbt_pkg::E_MIXED);
            bu.count = bu.count + 1'b1; halt_d = 1'b1;
          end else begin
            lvl_sum = {1'b0, itab_d} + {3'b000, isp_d[INDENT_COUNT_BITS-1:2]};
            lvl = lvl_sum[INDENT_COUNT_BITS] ? 16'(IndMax) : 16'(lvl_sum[INDENT_COUNT_BITS-1:0]);
            bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_LINE, end_at, end_at, line_d, lvl,
                                       sbt_pkg::E_NONE);
            bu.count = bu.count + 1'b1;
          end
        end
      end
      // an indent error halts on the line as it stands: no line advance
      if (!halt_d) begin
        line_d = (line_d == LineMax) ? LineMax : line_d + 1'b1;
        isp_d = '0; itab_d = '0; has_tok_d = 1'b0; mode_d = sbt_pkg::M_INDENT;
        // a final newline skips the flush pass, which in line-start mode would
        // only advance the line count once more; that advance is made here
        if (fin && b == 8'h0a && !halt_q) begin
          line_d = (line_d == LineMax) ? LineMax : line_d + 1'b1;
        end
      end
    end

    if (fin) begin
      bu.rec[bu.count[1:0]] = mk(sbt_pkg::K_DONE, endp, endp, line_d, '0, sbt_pkg::E_NONE);
      bu.count = bu.count + 1'b1;
      mode_d = sbt_pkg::M_INDENT; pos_d = '0; tstart_d = '0; line_d = '0;
      isp_d = '0; itab_d = '0; has_tok_d = 1'b0; sp_seen_d = 1'b0; tab_seen_d = 1'b0;
      dot_d = 1'b0; pop_d = '0; halt_d = 1'b0;
    end else begin
      pos_d = nxt;
    end
    if (bu.count != 3'd0) bu.rec[bu.count[1:0] - 2'd1].last_of_run = 1'b1;
    if (!valid_i) bu.count = '0;
  end

  assign burst_o = bu;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= sbt_pkg::M_INDENT; pos_q <= '0; tstart_q <= '0; line_q <= '0;
      isp_q <= '0; itab_q <= '0; has_tok_q <= 1'b0; sp_seen_q <= 1'b0;
      tab_seen_q <= 1'b0; dot_q <= 1'b0; pop_q <= '0; halt_q <= 1'b0;
    end else if (valid_i) begin
      mode_q <= mode_d; pos_q <= pos_d; tstart_q <= tstart_d; line_q <= line_d;
      isp_q <= isp_d; itab_q <= itab_d; has_tok_q <= has_tok_d; sp_seen_q <= sp_seen_d;
      tab_seen_q <= tab_seen_d; dot_q <= dot_d; pop_q <= pop_d; halt_q <= halt_d;
    end
  end

endmodule

// ===== rtl/core/sbt_back.sv =====
// Back end: record queue, takes a burst of up to four records, pops one a cycle while pop_i is high and not empty.
`timescale 1ns / 1ps
module sbt_back #(
  parameter int unsigned DEPTH_LOG2 = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbt_pkg::burst_t      burst_i,
  output logic                 room_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output sbt_pkg::out_item_t   rec_o
);

  localparam int unsigned Depth = 2 ** DEPTH_LOG2;

  sbt_pkg::out_item_t    mem_q [Depth];
  logic [DEPTH_LOG2-1:0] wp_q, rp_q;
  logic [DEPTH_LOG2:0]   cnt_q, cnt_d;
  logic                  do_pop;

  assign empty_o = cnt_q == '0;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rp_q];
  // room for a full burst whatever is popped this cycle
  assign room_o  = cnt_q <= (DEPTH_LOG2+1)'(Depth - sbt_pkg::MaxRec);
  assign cnt_d   = cnt_q + (DEPTH_LOG2+1)'(burst_i.count) - (DEPTH_LOG2+1)'(do_pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(sbt_pkg::MaxRec); i++) begin
      if (3'(i) < burst_i.count) mem_q[wp_q + DEPTH_LOG2'(i)] <= burst_i.rec[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + DEPTH_LOG2'(burst_i.count);
      rp_q  <= rp_q + DEPTH_LOG2'(do_pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== verif/script_byte_tokenizer_checker.sv =====
// Checker for the script byte tokenizer: predicts records per accepted byte and compares.
`timescale 1ns / 1ps
module script_byte_tokenizer_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  logic               full,
  input  sbt_pkg::in_item_t  in_item_i,
  input  logic               empty,
  input  logic               pop,
  input  sbt_pkg::out_item_t out_item_o,
  output int                 fail_count,
  output int                 pending_count
);

  localparam logic [23:0] OffMax  = 24'hFFFFFF;
  localparam logic [19:0] LineMax = 20'hFFFFF;
  localparam logic [15:0] IndMax  = 16'hFFFF;

  // Newline, quote, hash, dot, equals, space and tab codes.
  localparam logic [7:0] ChNl    = 8'h0a;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;

  sbt_pkg::mode_e mode;
  logic [23:0]    pos_q, tok_start;
  logic [19:0]    line_q;
  logic [15:0]    n_spaces, n_tabs;
  logic           has_tok, spaces_ever, tabs_ever, has_dot, halted;
  logic [2:0]     op_q;

  sbt_pkg::out_item_t burst[$];
  sbt_pkg::out_item_t expected_recs[$];

  function automatic logic [23:0] inc_off(input logic [23:0] v);
    return (v == OffMax) ? v : v + 24'd1;
  endfunction

  function automatic logic [15:0] inc_ind(input logic [15:0] v);
    return (v == IndMax) ? v : v + 16'd1;
  endfunction

  task automatic emit(input logic [4:0] k, input logic [23:0] s, input logic [23:0] e,
                      input logic [15:0] ind, input logic [2:0] err);
    sbt_pkg::out_item_t r;
    r.record_kind  = k;
    r.start_offset = s;
    r.end_offset   = e;
    r.line_number  = line_q;
    r.indent_depth = ind;
    r.error_code   = err;
    r.last_of_run  = 1'b0;
    burst.insert(burst.size(), r);
  endtask

  task automatic emit_tok(input logic [4:0] k, input logic [23:0] s, input logic [23:0] e);
    emit(k, s, e, 16'd0, sbt_pkg::E_NONE);
    has_tok = 1'b1;
  endtask

  task automatic emit_err(input logic [2:0] code, input logic [23:0] s, input logic [23:0] e);
    emit(sbt_pkg::K_ERROR, s, e, 16'd0, code);
    halted = 1'b1;
  endtask

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic close_line(input logic [23:0] at);
    logic [16:0] lvl;
    if (has_tok) begin
      if (n_spaces[1:0] != 2'd0) begin
        emit_err(sbt_pkg::E_INDENT, at, at);
        return;
      end
      if (n_spaces != 16'd0) spaces_ever = 1'b1;
      if (n_tabs != 16'd0) tabs_ever = 1'b1;
      if (spaces_ever && tabs_ever) begin
        emit_err(sbt_pkg::E_MIXED, at, at);
        return;
      end
      lvl = {1'b0, n_tabs} + {3'b0, n_spaces[15:2]};
      emit(sbt_pkg::K_LINE, at, at, lvl[16] ? IndMax : lvl[15:0], sbt_pkg::E_NONE);
    end
    if (line_q != LineMax) line_q = line_q + 20'd1;
    n_spaces = '0;
    n_tabs   = '0;
    has_tok  = 1'b0;
    mode     = sbt_pkg::M_INDENT;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic [23:0] p);
    logic [23:0] nxt;
    nxt = inc_off(p);
    case (mode)
      sbt_pkg::M_INDENT: begin
        if (b == ChSpace) begin
          n_spaces = inc_ind(n_spaces);
          return;
        end
        if (b == ChTab) begin
          n_tabs = inc_ind(n_tabs);
          return;
        end
      end
      sbt_pkg::M_NAME: begin
        if (is_alpha(b) || is_digit(b)) return;
        emit_tok(sbt_pkg::K_NAME, tok_start, p);
      end
      sbt_pkg::M_DOTSTART: begin
        if (is_digit(b)) begin
          mode = sbt_pkg::M_NUMBER;
          has_dot = 1'b1;
          return;
        end
        emit_err(sbt_pkg::E_DOT, tok_start, p);
        return;
      end
      sbt_pkg::M_NUMBER: begin
        if (is_digit(b)) return;
        if (b == ChDot && !has_dot) begin
          has_dot = 1'b1;
          return;
        end
        emit_tok(has_dot ? sbt_pkg::K_FLOAT : sbt_pkg::K_INT, tok_start, p);
      end
      sbt_pkg::M_STRING: begin
        if (b == ChQuote) begin
          emit_tok(sbt_pkg::K_STRING, tok_start, nxt);
          mode = sbt_pkg::M_IDLE;
          return;
        end
        if (b == ChNl) emit_err(sbt_pkg::E_STRING, tok_start, p);
        return;
      end
      sbt_pkg::M_OPER: begin
        if (b == ChEq) begin
          emit_tok(sbt_pkg::K_OPBASE + {op_q, 1'b1}, tok_start, nxt);
          mode = sbt_pkg::M_IDLE;
          return;
        end
        emit_tok(sbt_pkg::K_OPBASE + {op_q, 1'b0}, tok_start, p);
      end
      sbt_pkg::M_COMMENT: if (b != ChNl) return;
      default: ;
    endcase
    mode = sbt_pkg::M_IDLE;
    if (b == ChNl) begin
      close_line(p);
      return;
    end
    if (b == ChSpace || b == ChTab || b == 8'h0d) return;
    tok_start = p;
    if (is_alpha(b)) mode = sbt_pkg::M_NAME;
    else if (is_digit(b)) begin
      mode = sbt_pkg::M_NUMBER;
      has_dot = 1'b0;
    end else case (b)
      ChDot:   mode = sbt_pkg::M_DOTSTART;
      ChQuote: mode = sbt_pkg::M_STRING;
      ",":     emit_tok(sbt_pkg::K_COMMA, p, nxt);
      ":":     emit_tok(sbt_pkg::K_COLON, p, nxt);
      "(":     emit_tok(sbt_pkg::K_LPAREN, p, nxt);
      ")":     emit_tok(sbt_pkg::K_RPAREN, p, nxt);
      "=", "!", "*", "/", "+", "-": begin
        op_q = (b == "=") ? sbt_pkg::OP_EQ : (b == "!") ? sbt_pkg::OP_BANG :
               (b == "*") ? sbt_pkg::OP_STAR : (b == "/") ? sbt_pkg::OP_SLASH :
               (b == "+") ? sbt_pkg::OP_PLUS : sbt_pkg::OP_MINUS;
        mode = sbt_pkg::M_OPER;
      end
      ChHash:  mode = sbt_pkg::M_COMMENT;
      default: emit_err(sbt_pkg::E_CHAR, p, nxt);
    endcase
  endtask

  task automatic clear_state();
    mode = sbt_pkg::M_INDENT; pos_q = '0; tok_start = '0; line_q = '0;
    n_spaces = '0; n_tabs = '0; has_tok = 1'b0; spaces_ever = 1'b0; tabs_ever = 1'b0;
    has_dot = 1'b0; halted = 1'b0; op_q = '0;
  endtask

  // Builds the expected records for one accepted byte.
  task automatic predict_byte(input sbt_pkg::in_item_t it);
    logic [23:0] endp;
    burst.delete();
    if (!halted) scan_byte(it.text_byte, pos_q);
    if (it.final_byte) begin
      endp = inc_off(pos_q);
      if (!halted) begin
        case (mode)
          sbt_pkg::M_NAME:     emit_tok(sbt_pkg::K_NAME, tok_start, endp);
          sbt_pkg::M_NUMBER:   emit_tok(has_dot ? sbt_pkg::K_FLOAT : sbt_pkg::K_INT,
                                        tok_start, endp);
          sbt_pkg::M_DOTSTART: emit_err(sbt_pkg::E_DOT, tok_start, endp);
          sbt_pkg::M_STRING:   emit_err(sbt_pkg::E_STRING, tok_start, endp);
          sbt_pkg::M_OPER:     emit_tok(sbt_pkg::K_OPBASE + {op_q, 1'b0}, tok_start, endp);
          default: ;
        endcase
        if (!halted) close_line(endp);
      end
      emit(sbt_pkg::K_DONE, endp, endp, 16'd0, sbt_pkg::E_NONE);
      clear_state();
    end else begin
      pos_q = inc_off(pos_q);
    end
    if (burst.size() > 0) burst[burst.size()-1].last_of_run = 1'b1;
    foreach (burst[i]) expected_recs.insert(expected_recs.size(), burst[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sbt_pkg::out_item_t want;
    if (!rst_ni) begin
      clear_state();
      expected_recs.delete();
      fail_count <= 0;
      pending_count = 0;
    end else begin
      // Output beat first: its expectation predates any byte taken this edge.
      if (pop && !empty) begin
        if (expected_recs.size() == 0) begin
          if (fail_count < 10) $display("%0t unexpected record %p", $realtime, out_item_o);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_recs.pop_front();
          if (out_item_o !== want) begin
            if (fail_count < 10)
              $display("%0t mismatch: exp %p got %p", $realtime, want, out_item_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (push && !full) predict_byte(in_item_i);
      pending_count = expected_recs.size();
    end
  end

endmodule

// ===== verif/script_byte_tokenizer_tb.sv =====
// Testbench top for the script byte tokenizer: stimulus, idling and verdict.
`timescale 1ns / 1ps
module script_byte_tokenizer_tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  logic               full, empty;
  sbt_pkg::in_item_t  in_item_i = '0;
  sbt_pkg::out_item_t out_item_o;
  int                 fail_count, pending_count;
  bit                 draining = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  script_byte_tokenizer dut (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .out_item_o
  );

  script_byte_tokenizer_checker u_checker (
    .clk_i, .rst_ni, .push, .full, .in_item_i, .empty, .pop, .out_item_o,
    .fail_count, .pending_count
  );

  // One beat into the block; gap drawn per byte, zero gaps in bursty stretches.
  task automatic send_byte(input logic [7:0] b, input logic fin, input bit gaps);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 16) : 0;
    if (wait_n != 0) begin
      push <= 1'b0;
      repeat (wait_n) @(negedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= '{text_byte: b, final_byte: fin};
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input bit gaps);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1, gaps);
  endtask

  // Random byte biased toward tokenizer alphabet so lines get deep.
  function automatic logic [7:0] pick_byte();
    string alpha;
    alpha = "ab_Z09.\"\",:()=!*/+-#  \t\n\r=.";
    if ($urandom_range(0, 15) == 0) return 8'($urandom);
    return alpha[$urandom_range(0, alpha.len() - 1)];
  endfunction

  // Consumer: random stall before each result, sometimes none, drawn from a narrower range while draining.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (draining) stall = $urandom_range(0, 2);
      pop <= 1'b0;
      repeat (stall) @(negedge clk_i);
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  initial begin
    int len;
    bit gaps;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: operators, numbers, strings, lone dot, bad char, indents, mixing.
    send_text("a_1=b==!x!=*3*=/2/=+4.5+=-1-=,:()#c\n", 1'b1);
    send_text("    1.2.3 \"s\"\n", 1'b0);
    send_text(". ", 1'b1);
    send_text("\"open\n", 1'b0);
    send_text("x$", 1'b1);
    send_text("   y\n", 1'b1);
    send_text("\tz\n    w\n", 1'b0);
    send_text("\n\n5.", 1'b1);
    send_text("\"eof", 1'b1);
    send_byte(8'hff, 1'b1, 1'b1);

    // Pause until every expected record has drained.
    push <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);

    // Random texts, mostly well-formed token soup, some raw noise.
    for (int n = 0; n < 8; n++) begin
      len = $urandom_range(1, 10);
      gaps = $urandom_range(0, 2) != 0;
      for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1, gaps);
    end
    push <= 1'b0;

    draining = 1'b1;
    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== script_byte_tokenizer.f =====
rtl/core/sbt_pkg.sv
rtl/core/sbt_front.sv
rtl/core/sbt_back.sv
rtl/core/script_byte_tokenizer.sv
verif/script_byte_tokenizer_checker.sv
verif/script_byte_tokenizer_tb.sv
